// ===== rtl/adc_iir_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package adc_iir_pkg;

  localparam int NUM_CHANNELS = 12;
  localparam int CHAN_W       = 4;
  localparam int ADDR_W       = $clog2(NUM_CHANNELS);
  localparam int DATA_W       = 16;
  localparam int FILTER_SHIFT = 3;
  localparam int CFG_IDX_W    = 4;

  localparam logic [CHAN_W-1:0] LAST_CHANNEL = 4'd11;

  // ADC channel numbers.
  localparam logic [CHAN_W-1:0] CH_ANG0_C = 4'd0;
  localparam logic [CHAN_W-1:0] CH_ANG0_B = 4'd1;
  localparam logic [CHAN_W-1:0] CH_ANG0_A = 4'd2;
  localparam logic [CHAN_W-1:0] CH_ANG1_C = 4'd3;
  localparam logic [CHAN_W-1:0] CH_ANG1_B = 4'd4;
  localparam logic [CHAN_W-1:0] CH_ANG1_A = 4'd5;
  localparam logic [CHAN_W-1:0] CH_M1_C   = 4'd6;
  localparam logic [CHAN_W-1:0] CH_M1_B   = 4'd7;
  localparam logic [CHAN_W-1:0] CH_M1_A   = 4'd8;
  localparam logic [CHAN_W-1:0] CH_M0_C   = 4'd9;
  localparam logic [CHAN_W-1:0] CH_M0_B   = 4'd10;
  localparam logic [CHAN_W-1:0] CH_M0_A   = 4'd11;

  // Output quantity codes.
  localparam logic [CHAN_W-1:0] Q_M0_IA    = 4'd0;
  localparam logic [CHAN_W-1:0] Q_M0_IB    = 4'd1;
  localparam logic [CHAN_W-1:0] Q_M0_IC    = 4'd2;
  localparam logic [CHAN_W-1:0] Q_M1_IA    = 4'd3;
  localparam logic [CHAN_W-1:0] Q_M1_IB    = 4'd4;
  localparam logic [CHAN_W-1:0] Q_M1_IC    = 4'd5;
  localparam logic [CHAN_W-1:0] Q_M0_ANG_A = 4'd6;
  localparam logic [CHAN_W-1:0] Q_M0_ANG_B = 4'd7;
  localparam logic [CHAN_W-1:0] Q_M0_ANG_C = 4'd8;
  localparam logic [CHAN_W-1:0] Q_M1_ANG_A = 4'd9;
  localparam logic [CHAN_W-1:0] Q_M1_ANG_B = 4'd10;
  localparam logic [CHAN_W-1:0] Q_M1_ANG_C = 4'd11;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR0_SWAP = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR1_SWAP = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_M0_OFFSET_A = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_M0_OFFSET_B = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_M0_OFFSET_C = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_M1_OFFSET_A = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_M1_OFFSET_B = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_M1_OFFSET_C = 4'd7;

  typedef struct packed {
    logic                     motor0_swap;
    logic                     motor1_swap;
    logic signed [DATA_W-1:0] m0_offset_a;
    logic signed [DATA_W-1:0] m0_offset_b;
    logic signed [DATA_W-1:0] m0_offset_c;
    logic signed [DATA_W-1:0] m1_offset_a;
    logic signed [DATA_W-1:0] m1_offset_b;
    logic signed [DATA_W-1:0] m1_offset_c;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/adc_iir_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module adc_iir_cfg
  import adc_iir_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data,
  output cfg_t                      cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MOTOR0_SWAP: cfg_r.motor0_swap <= cfg_data[0];
        REG_MOTOR1_SWAP: cfg_r.motor1_swap <= cfg_data[0];
        REG_M0_OFFSET_A: cfg_r.m0_offset_a <= cfg_data;
        REG_M0_OFFSET_B: cfg_r.m0_offset_b <= cfg_data;
        REG_M0_OFFSET_C: cfg_r.m0_offset_c <= cfg_data;
        REG_M1_OFFSET_A: cfg_r.m1_offset_a <= cfg_data;
        REG_M1_OFFSET_B: cfg_r.m1_offset_b <= cfg_data;
        REG_M1_OFFSET_C: cfg_r.m1_offset_c <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/adc_iir_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module adc_iir_mem
  import adc_iir_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0]       mem_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_r;
  logic [DATA_W-1:0]       rd_data_r;

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem_r[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/adc_iir_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module adc_iir_calc
  import adc_iir_pkg::*;
(
  input  wire logic        [CHAN_W-1:0] chan,
  input  wire logic        [DATA_W-1:0] sample,
  input  wire logic signed [DATA_W-1:0] old,
  input  cfg_t                          cfg,
  output logic signed      [DATA_W-1:0] upd,
  output logic             [CHAN_W-1:0] quantity,
  output logic signed      [DATA_W-1:0] value
);

  logic signed [DATA_W-1:0] centred;
  logic signed [DATA_W-1:0] delta;
  logic signed [DATA_W-1:0] step;
  logic signed [DATA_W:0]   sum;
  logic signed [DATA_W-1:0] off;
  logic                     is_current;

  // Subtracting the midpoint from an unsigned word just flips its top bit.
  assign centred = {~sample[DATA_W-1], sample[DATA_W-2:0]};
  assign delta   = centred - old;
  assign step    = delta >>> FILTER_SHIFT;
  assign sum     = {old[DATA_W-1], old} + {step[DATA_W-1], step};

  always_comb begin
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      upd = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      upd = sum[DATA_W-1:0];
    end
  end

  always_comb begin
    quantity   = Q_M0_IA;
    off        = '0;
    is_current = 1'b1;
    unique case (chan)
      CH_ANG0_C: begin quantity = Q_M0_ANG_C; is_current = 1'b0; end
      CH_ANG0_B: begin quantity = Q_M0_ANG_B; is_current = 1'b0; end
      CH_ANG0_A: begin quantity = Q_M0_ANG_A; is_current = 1'b0; end
      CH_ANG1_C: begin quantity = Q_M1_ANG_C; is_current = 1'b0; end
      CH_ANG1_B: begin quantity = Q_M1_ANG_B; is_current = 1'b0; end
      CH_ANG1_A: begin quantity = Q_M1_ANG_A; is_current = 1'b0; end
      CH_M1_C: begin
        quantity = Q_M1_IC;
        off      = cfg.m1_offset_c;
      end
      CH_M1_B: begin
        quantity = cfg.motor1_swap ? Q_M1_IA : Q_M1_IB;
        off      = cfg.motor1_swap ? cfg.m1_offset_a : cfg.m1_offset_b;
      end
      CH_M1_A: begin
        quantity = cfg.motor1_swap ? Q_M1_IB : Q_M1_IA;
        off      = cfg.motor1_swap ? cfg.m1_offset_b : cfg.m1_offset_a;
      end
      CH_M0_C: begin
        quantity = Q_M0_IC;
        off      = cfg.m0_offset_c;
      end
      CH_M0_B: begin
        quantity = cfg.motor0_swap ? Q_M0_IA : Q_M0_IB;
        off      = cfg.motor0_swap ? cfg.m0_offset_a : cfg.m0_offset_b;
      end
      default: begin
        quantity = cfg.motor0_swap ? Q_M0_IB : Q_M0_IA;
        off      = cfg.motor0_swap ? cfg.m0_offset_b : cfg.m0_offset_a;
      end
    endcase
  end

  assign value = is_current ? upd - off : upd;

endmodule

`default_nettype wire

// ===== rtl/adc_phase_current_iir_frontend_top.sv =====
// ADC front end with a first-order smoothing filter for each of twelve channels.
// Input channel: in_valid/in_stall carry one word of in_chan and in_sample; a word
// is taken at a clock edge with in_valid high and in_stall low. Words whose channel
// is above eleven are taken and dropped without touching any filter.
// Output channel: out_valid/out_stall carry out_quantity and out_value.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while no word is in flight.
// The compute stage registers a taken word and the output register its result.
// One word per clock is sustained while the receiver does not stall: the filter
// memory is read as a word arrives and written back as it leaves the compute stage,
// and a one-entry bypass of the last write covers back-to-back words on one channel.
// When the receiver stalls, the result holds in the output register and the word
// behind it holds in the compute stage; in_stall rises only when both are full.
// Synchronous reset clears the configuration registers, empties the pipeline and
// makes every filter value read as zero at once, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module adc_phase_current_iir_frontend_top
  import adc_iir_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic        [CHAN_W-1:0] in_chan,
  input  wire logic        [DATA_W-1:0] in_sample,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic             [CHAN_W-1:0] out_quantity,
  output logic signed      [DATA_W-1:0] out_value,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic     [CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [DATA_W-1:0] cfg_data
);

  cfg_t cfg;

  logic                     accept;
  logic                     in_range;
  logic                     out_free;
  logic                     s1_adv;

  logic                     s1_vld_r, s1_vld_nxt;
  logic        [CHAN_W-1:0] s1_chan_r;
  logic        [DATA_W-1:0] s1_sample_r;

  logic                     byp_vld_r;
  logic        [ADDR_W-1:0] byp_addr_r;
  logic signed [DATA_W-1:0] byp_data_r;

  logic        [DATA_W-1:0] rd_data;
  logic signed [DATA_W-1:0] old;
  logic signed [DATA_W-1:0] upd;
  logic        [CHAN_W-1:0] quantity;
  logic signed [DATA_W-1:0] value;

  logic                     out_valid_r, out_valid_nxt;
  logic        [CHAN_W-1:0] out_quantity_r;
  logic signed [DATA_W-1:0] out_value_r;

  assign cfg_ready = 1'b1;

  adc_iir_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_vld_r && out_free;
  assign in_stall = s1_vld_r && !out_free;
  assign accept   = in_valid && !in_stall;
  assign in_range = in_chan <= LAST_CHANNEL;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (s1_adv || !s1_vld_r) begin
      s1_vld_nxt = accept && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_chan_r   <= in_chan;
      s1_sample_r <= in_sample;
    end
  end

  adc_iir_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (s1_adv),
    .wr_addr (s1_chan_r[ADDR_W-1:0]),
    .wr_data (upd),
    .rd_en   (accept && in_range),
    .rd_addr (in_chan[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // The bypass always holds the most recent write, so a match is never stale.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_vld_r <= 1'b0;
    end else if (s1_adv) begin
      byp_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      byp_addr_r <= s1_chan_r[ADDR_W-1:0];
      byp_data_r <= upd;
    end
  end

  assign old = (byp_vld_r && byp_addr_r == s1_chan_r[ADDR_W-1:0]) ? byp_data_r : rd_data;

  adc_iir_calc u_calc (
    .chan     (s1_chan_r),
    .sample   (s1_sample_r),
    .old      (old),
    .cfg      (cfg),
    .upd      (upd),
    .quantity (quantity),
    .value    (value)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_quantity_r <= quantity;
      out_value_r    <= value;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_quantity = out_quantity_r;
  assign out_value    = out_value_r;

endmodule

`default_nettype wire
